### rtl/assert_macros.svh
// Assertion helpers used by vector_normalize_2d.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

### rtl/vn2d_pkg.sv
// ----------------------------------------------------------------------------
// vn2d_pkg
// Widths, stage counts and shared types of the 2D vector normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package vn2d_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 15;

    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int ABS_W   = COORD_WIDTH;
    localparam int SQ_W    = 2 * ABS_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int MAGN_W  = 17;
    localparam int UNIT_W  = FRAC_BITS + 1;
    localparam int QUO_W   = 2 * FRAC_BITS + 1;

    localparam int DIV_STEPS  = QUO_W;
    localparam int QSQ_STEPS  = FRAC_BITS + 1;
    localparam int LANE_DEPTH = DIV_STEPS + QSQ_STEPS;
    localparam int ROOT_STEPS = (SUM_W + 1) / 2;
    localparam int MAG_DLY    = LANE_DEPTH - ROOT_STEPS;
    localparam int HEAD_STAGES = 3;
    localparam int TOTAL_STAGES = HEAD_STAGES + LANE_DEPTH + 1;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic zero;
    } flags_t;

endpackage

`default_nettype wire

### rtl/vn2d_lane.sv
// ----------------------------------------------------------------------------
// vn2d_lane
// One component lane: pipelined long division of a^2 * 2^(2F) by the squared
// length, then a pipelined integer square root of the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module vn2d_lane (
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire logic [vn2d_pkg::SQ_W-1:0]      sq,
    input  wire logic [vn2d_pkg::SUM_W-1:0]     sum,
    output logic      [vn2d_pkg::UNIT_W-1:0]    quo
);

    localparam int SUM_W = vn2d_pkg::SUM_W;
    localparam int QUO_W = vn2d_pkg::QUO_W;
    localparam int DIV_STEPS = vn2d_pkg::DIV_STEPS;
    localparam int QSQ_STEPS = vn2d_pkg::QSQ_STEPS;

    logic [SUM_W:0]   rem_reg [DIV_STEPS];
    logic [SUM_W-1:0] dvs_reg [DIV_STEPS];
    logic [QUO_W-1:0] q_reg   [DIV_STEPS];

    logic [QUO_W-1:0] op_reg  [QSQ_STEPS];
    logic [QUO_W:0]   res_reg [QSQ_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [SUM_W:0]   rem_in;
        logic [SUM_W-1:0] dvs_in;
        logic [QUO_W-1:0] q_in;
        logic [SUM_W:0]   diff;
        logic [SUM_W-1:0] r;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in = (SUM_W + 1)'(sq);
            assign dvs_in = sum;
            assign q_in   = '0;
        end
        else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        always_comb
        begin
            ge   = rem_in >= {1'b0, dvs_in};
            diff = rem_in - {1'b0, dvs_in};
            r    = ge ? diff[SUM_W-1:0] : rem_in[SUM_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= {r, 1'b0};
                dvs_reg[k] <= dvs_in;
                q_reg[k]   <= {q_in[QUO_W-2:0], ge};
            end
        end
    end

    for (genvar j = 0; j < QSQ_STEPS; j++) begin : g_sqrt
        localparam logic [QUO_W:0] ONE = (QUO_W + 1)'(1) << (2 * (QSQ_STEPS - 1 - j));
        logic [QUO_W-1:0] op_in;
        logic [QUO_W:0]   res_in;
        logic [QUO_W:0]   trial;
        logic [QUO_W:0]   rem;
        logic             ge;

        if (j == 0) begin : g_first
            assign op_in  = q_reg[DIV_STEPS-1];
            assign res_in = '0;
        end
        else begin : g_rest
            assign op_in  = op_reg[j-1];
            assign res_in = res_reg[j-1];
        end

        always_comb
        begin
            trial = res_in + ONE;
            ge    = {1'b0, op_in} >= trial;
            rem   = {1'b0, op_in} - trial;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                op_reg[j]  <= ge ? rem[QUO_W-1:0] : op_in;
                res_reg[j] <= ge ? (res_in >> 1) + ONE : res_in >> 1;
            end
        end
    end

    assign quo = res_reg[QSQ_STEPS-1][vn2d_pkg::UNIT_W-1:0];

endmodule

`default_nettype wire

### rtl/vector_normalize_2d.sv
// ----------------------------------------------------------------------------
// vector_normalize_2d
// Length and Q1.15 unit vector of the vector from a begin to an end point.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction per cycle, 51 register stages. The depth is
// set by the per-component divide-then-root lane (31 division steps plus 16
// square root steps, one step per stage); the length root runs alongside it.
// A stall at the output holds the whole pipeline.
`default_nettype none
`include "assert_macros.svh"

module vector_normalize_2d (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire logic signed [vn2d_pkg::COORD_WIDTH-1:0] x_begin,
    input  wire logic signed [vn2d_pkg::COORD_WIDTH-1:0] y_begin,
    input  wire logic signed [vn2d_pkg::COORD_WIDTH-1:0] x_end,
    input  wire logic signed [vn2d_pkg::COORD_WIDTH-1:0] y_end,
    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output logic signed [vn2d_pkg::UNIT_W-1:0]           unit_x,
    output logic signed [vn2d_pkg::UNIT_W-1:0]           unit_y,
    output logic        [vn2d_pkg::MAGN_W-1:0]           magnitude,
    output logic                                         zero_length
);

    localparam int CW     = vn2d_pkg::COORD_WIDTH;
    localparam int DIFF_W = vn2d_pkg::DIFF_W;
    localparam int ABS_W  = vn2d_pkg::ABS_W;
    localparam int SQ_W   = vn2d_pkg::SQ_W;
    localparam int SUM_W  = vn2d_pkg::SUM_W;
    localparam int MAGN_W = vn2d_pkg::MAGN_W;
    localparam int UNIT_W = vn2d_pkg::UNIT_W;
    localparam int TOTAL  = vn2d_pkg::TOTAL_STAGES;
    localparam int LANE_DEPTH = vn2d_pkg::LANE_DEPTH;
    localparam int ROOT_STEPS = vn2d_pkg::ROOT_STEPS;
    localparam int MAG_DLY    = vn2d_pkg::MAG_DLY;
    localparam logic [UNIT_W-1:0] UNIT_MAX = {1'b0, {(UNIT_W - 1){1'b1}}};

    logic [TOTAL-1:0] vld_reg;
    logic             adv;

    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic [ABS_W-1:0]         ax, ay;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg, sqx3_reg, sqy3_reg;
    logic [SUM_W-1:0]         sum_reg;
    vn2d_pkg::flags_t         flg2_reg, flg3_reg;
    vn2d_pkg::flags_t         flg_reg [LANE_DEPTH];

    logic [SUM_W-1:0] rop_reg  [ROOT_STEPS];
    logic [SUM_W:0]   rres_reg [ROOT_STEPS];
    logic [MAGN_W-1:0] mag_dly_reg [MAG_DLY];

    logic [UNIT_W-1:0] qx, qy;
    logic [UNIT_W-1:0] unit_x_reg, unit_y_reg, unit_x_next, unit_y_next;
    logic [MAGN_W-1:0] mag_reg;
    logic              zero_reg;
    vn2d_pkg::flags_t  flg_last;

    assign adv      = !vld_reg[TOTAL-1] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[TOTAL-2:0], in_valid};
        end
    end

    always_comb
    begin
        ax = dx_reg[DIFF_W-1] ? ABS_W'(-dx_reg) : ABS_W'(dx_reg);
        ay = dy_reg[DIFF_W-1] ? ABS_W'(-dy_reg) : ABS_W'(dy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg <= {x_end[CW-1], x_end} - {x_begin[CW-1], x_begin};
            dy_reg <= {y_end[CW-1], y_end} - {y_begin[CW-1], y_begin};

            sqx_reg        <= ax[ABS_W-1:0] * ax[ABS_W-1:0];
            sqy_reg        <= ay[ABS_W-1:0] * ay[ABS_W-1:0];
            flg2_reg.neg_x <= dx_reg[DIFF_W-1];
            flg2_reg.neg_y <= dy_reg[DIFF_W-1];
            flg2_reg.zero  <= (dx_reg == '0) && (dy_reg == '0);

            sum_reg  <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
            sqx3_reg <= sqx_reg;
            sqy3_reg <= sqy_reg;
            flg3_reg <= flg2_reg;

            flg_reg[0] <= flg3_reg;
            for (int i = 1; i < LANE_DEPTH; i++)
            begin
                flg_reg[i] <= flg_reg[i-1];
            end
        end
    end

    for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
        localparam logic [SUM_W:0] ONE = (SUM_W + 1)'(1) << (2 * (ROOT_STEPS - 1 - j));
        logic [SUM_W-1:0] op_in;
        logic [SUM_W:0]   res_in;
        logic [SUM_W:0]   trial;
        logic [SUM_W:0]   rem;
        logic             ge;

        if (j == 0) begin : g_first
            assign op_in  = sum_reg;
            assign res_in = '0;
        end
        else begin : g_rest
            assign op_in  = rop_reg[j-1];
            assign res_in = rres_reg[j-1];
        end

        always_comb
        begin
            trial = res_in + ONE;
            ge    = {1'b0, op_in} >= trial;
            rem   = {1'b0, op_in} - trial;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rop_reg[j]  <= ge ? rem[SUM_W-1:0] : op_in;
                rres_reg[j] <= ge ? (res_in >> 1) + ONE : res_in >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_dly_reg[0] <= rres_reg[ROOT_STEPS-1][MAGN_W-1:0];
            for (int i = 1; i < MAG_DLY; i++)
            begin
                mag_dly_reg[i] <= mag_dly_reg[i-1];
            end
        end
    end

    vn2d_lane u_lane_x (
        .clk (clk),
        .en  (adv),
        .sq  (sqx3_reg),
        .sum (sum_reg),
        .quo (qx)
    );

    vn2d_lane u_lane_y (
        .clk (clk),
        .en  (adv),
        .sq  (sqy3_reg),
        .sum (sum_reg),
        .quo (qy)
    );

    assign flg_last = flg_reg[LANE_DEPTH-1];

    always_comb
    begin
        if (flg_last.zero)
        begin
            unit_x_next = '0;
        end
        else if (flg_last.neg_x)
        begin
            unit_x_next = -qx;
        end
        else
        begin
            unit_x_next = qx[UNIT_W-1] ? UNIT_MAX : qx;
        end

        if (flg_last.zero)
        begin
            unit_y_next = '0;
        end
        else if (flg_last.neg_y)
        begin
            unit_y_next = -qy;
        end
        else
        begin
            unit_y_next = qy[UNIT_W-1] ? UNIT_MAX : qy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            unit_x_reg <= unit_x_next;
            unit_y_reg <= unit_y_next;
            mag_reg    <= flg_last.zero ? '0 : mag_dly_reg[MAG_DLY-1];
            zero_reg   <= flg_last.zero;
        end
    end

    assign out_valid   = vld_reg[TOTAL-1];
    assign unit_x      = unit_x_reg;
    assign unit_y      = unit_y_reg;
    assign magnitude   = mag_reg;
    assign zero_length = zero_reg;

    `ASSERT_CLK(a_zero_clears, !(out_valid && zero_length) || (unit_x == '0 && unit_y == '0 && magnitude == '0), "zero-length transaction with nonzero result")
    `ASSERT_CLK(a_nonzero_mag, !(out_valid && !zero_length) || (magnitude != '0), "nonzero vector with zero magnitude")
    `ASSERT_NEXT(a_stall_holds, !adv, vld_reg == $past(vld_reg), "pipeline moved during stall")

endmodule

`default_nettype wire
